// File: rtl/core/tca_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed-point constants for the Taylor-series cosine block.
// No dependencies; imported by tca_ctrl, tca_dp and taylor_cosine_to_accuracy.
package tca_pkg;

  // port widths
  localparam int ANG_W     = 32;
  localparam int ACC_W     = 31;
  localparam int COS_W     = 32;
  localparam int OUT_CNT_W = 5;

  // internal Q8.40 formats (sum Q10.40)
  localparam int FRAC_W    = 40;
  localparam int X_W       = 48;
  localparam int TM_W      = 48;
  localparam int SUM_W     = 50;
  localparam int RND_SHIFT = 10;
  localparam int FMAG_W    = SUM_W - RND_SHIFT;

  // angle reduction: one conditional subtract of 2*pi << j per cycle
  localparam int RED_STEPS = 5;
  localparam logic [X_W-1:0] TWO_PI_Q40 = 48'h0648_7ED5_110B;

  // multi-cycle multiplier: 48-bit operand times one 16-bit digit per cycle
  localparam int DIG_W      = 16;
  localparam int MUL_DIGITS = TM_W / DIG_W;
  localparam int PROD_W     = 2 * TM_W;

  // restoring divider: several quotient bits per cycle
  localparam int DVD_W     = PROD_W - FRAC_W;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = DVD_W / DIV_BITS;

  // controller step counter
  localparam int CNT_W = 3;

  localparam logic [ACC_W-1:0] ACC_RESET = 31'd1074;
  localparam logic [COS_W-1:0] COS_MAX   = 32'h7FFF_FFFF;
  localparam logic [COS_W-1:0] COS_MIN   = 32'h8000_0000;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic red_step;
    logic red_last;
    logic mul_step;
    logic sq_done;
    logic add_term;
    logic div_load;
    logic div_step;
    logic div_last;
    logic fin;
    logic out_load;
  } tca_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic more_terms;
    logic out_free;
  } tca_stat_t;

endpackage

// File: rtl/core/taylor_cosine_to_accuracy.sv
`timescale 1ns / 1ps
// Taylor-series cosine of a Q8.24 angle, summed until the term drops to the
// accuracy threshold or MAX_TERMS terms have been added (terms_added gives the
// count). The angle is reduced modulo 2*pi and squared in the 48x16 digit
// multiplier; each term then takes a check, a pass through the multiplier, a
// rounding step and the divider by (2k-1)(2k), which retires eight quotient
// bits a cycle. A new angle is taken only when idle, after the last result has
// been loaded into the output register; that result waits there, so the next
// angle is taken while it is still unread.
// Depends on tca_pkg, tca_ctrl and tca_dp.
module taylor_cosine_to_accuracy #(
  parameter int MAX_TERMS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tca_pkg::ACC_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tca_pkg::ANG_W-1:0] angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tca_pkg::COS_W-1:0] cosine,
  output logic [tca_pkg::OUT_CNT_W-1:0]    terms_added,
  output logic                             hit_term_limit
);
  import tca_pkg::*;

  tca_cmd_t  cmd;
  tca_stat_t stat;

  // sequencer
  tca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and output register
  tca_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .angle          (angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cosine         (cosine),
    .terms_added    (terms_added),
    .hit_term_limit (hit_term_limit)
  );

endmodule

// File: rtl/core/tca_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the Taylor-series cosine: reduction, squaring, term loop, output.
// Depends on tca_pkg for the command and status structs and step counts.
module tca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tca_pkg::tca_stat_t  stat,
  output tca_pkg::tca_cmd_t   cmd
);
  import tca_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQR  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DLD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             cnt_last;

  assign cnt_last = (cnt == '0);
  assign in_ready = (state == S_IDLE);

  // next state, step counter and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = CNT_W'(RED_STEPS - 1);
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        cmd.red_last = cnt_last;
        if (cnt_last) begin
          cnt_next   = CNT_W'(MUL_DIGITS - 1);
          state_next = S_SQ;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_SQ: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt_last) begin
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sq_done = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (stat.more_terms) begin
          cmd.add_term = 1'b1;
          cnt_next     = CNT_W'(MUL_DIGITS - 1);
          state_next   = S_MUL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt_last) begin
          state_next = S_DLD;
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        cnt_next     = CNT_W'(DIV_STEPS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = cnt_last;
        cnt_next     = cnt - 1'b1;
        if (cnt_last) begin
          state_next = S_CHK;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: rtl/core/tca_dp.sv
`timescale 1ns / 1ps
// Datapath for the Taylor-series cosine: reducer, digit multiplier, divider,
// accumulator, accuracy register and output register. Depends on tca_pkg.
module tca_dp #(
  parameter int MAX_TERMS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tca_pkg::tca_cmd_t               cmd,
  output tca_pkg::tca_stat_t              stat,
  input  logic                            cfg_write,
  input  logic [tca_pkg::ACC_W-1:0]       cfg_data,
  input  logic signed [tca_pkg::ANG_W-1:0] angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [tca_pkg::COS_W-1:0] cosine,
  output logic [tca_pkg::OUT_CNT_W-1:0]   terms_added,
  output logic                            hit_term_limit
);
  import tca_pkg::*;

  localparam int N_W = $clog2(MAX_TERMS + 1);
  localparam int D_W = $clog2(4 * MAX_TERMS * MAX_TERMS);
  localparam int P_W = 2 * N_W + 2;

  logic [ACC_W-1:0]        accuracy;

  logic [ANG_W-1:0]        ang_u;
  logic [ANG_W-1:0]        amag;
  logic [X_W-1:0]          rx;
  logic [X_W-1:0]          rx_next;
  logic [X_W-1:0]          rdiv;

  logic [TM_W-1:0]         ma;
  logic [TM_W-1:0]         mb;
  logic [2*TM_W-DIG_W-1:0] pp;
  logic [PROD_W-1:0]       acc;
  logic [PROD_W-1:0]       acc_next;
  logic [DVD_W-1:0]        d_half;
  logic [PROD_W-1:0]       rnd;

  logic [DVD_W-1:0]        dvd;
  logic [D_W-1:0]          rem;
  logic [DVD_W-1:0]        div_q;
  logic [D_W-1:0]          div_r;

  logic [TM_W-1:0]         tm;
  logic [TM_W-1:0]         x2;
  logic [TM_W-1:0]         thr;
  logic                    tm_gt_thr;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] tm_s;
  logic [N_W-1:0]          n;
  logic [N_W-1:0]          n_inc;
  logic                    tneg;
  logic [D_W-1:0]          d;
  logic [N_W:0]            k2;
  logic [N_W:0]            km;
  logic [P_W-1:0]          dprod;

  logic [SUM_W-1:0]        sum_u;
  logic [SUM_W-1:0]        smag;
  logic [SUM_W-1:0]        radd;
  logic                    fneg;
  logic [FMAG_W-1:0]       fmag;
  logic [COS_W-1:0]        cos_sat;

  // accuracy register
  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy <= ACC_RESET;
    end else if (cfg_write) begin
      accuracy <= cfg_data;
    end
  end

  // angle magnitude and reduction step against 2*pi << j
  assign ang_u   = angle;
  assign amag    = ang_u[ANG_W-1] ? (~ang_u + ANG_W'(1)) : ang_u;
  assign rx_next = (rx >= rdiv) ? (rx - rdiv) : rx;

  // multiplier digit step, high digit first
  assign pp       = ma * mb[TM_W-1 -: DIG_W];
  assign acc_next = {acc[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(pp);

  // round at bit 40, folding in half the divisor for the term update
  assign d_half = cmd.div_load ? DVD_W'(d >> 1) : '0;
  assign rnd    = acc + {d_half, 1'b1, {(FRAC_W-1){1'b0}}};

  // divisor (2k-1)(2k) for the term being added, k = n + 1
  assign n_inc = n + N_W'(1);
  assign k2    = {n_inc, 1'b0};
  assign km    = k2 - (N_W+1)'(1);
  assign dprod = P_W'(k2) * P_W'(km);

  // restoring divider, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [D_W-1:0]   r;
    logic [DVD_W-1:0] q;
    logic [D_W:0]     t;
    logic [D_W:0]     diff;
    logic             ge;
    r    = rem;
    q    = dvd;
    t    = '0;
    diff = '0;
    ge   = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t    = {r, q[DVD_W-1]};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      q    = {q[DVD_W-2:0], ge};
      r    = ge ? diff[D_W-1:0] : t[D_W-1:0];
    end
    div_q = q;
    div_r = r;
  end

  // loop status
  assign thr       = TM_W'({accuracy, {RND_SHIFT{1'b0}}});
  assign tm_gt_thr = (tm > thr);
  assign tm_s      = signed'(SUM_W'(tm));

  assign stat.more_terms = (n < N_W'(MAX_TERMS)) && tm_gt_thr;
  assign stat.out_free   = !out_valid || out_ready;

  // final rounding: magnitude of the sum, halves away from zero
  assign sum_u = sum;
  assign smag  = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
  assign radd  = smag + SUM_W'(1 << (RND_SHIFT - 1));

  // saturation to Q2.30
  always_comb begin
    if (!fneg) begin
      cos_sat = (fmag > FMAG_W'(COS_MAX)) ? COS_MAX : fmag[COS_W-1:0];
    end else begin
      cos_sat = (fmag > FMAG_W'(COS_MIN)) ? COS_MIN : (~fmag[COS_W-1:0] + COS_W'(1));
    end
  end

  // reducer, multiplier, divider and series registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx   <= {amag, {(X_W-ANG_W){1'b0}}};
      rdiv <= TWO_PI_Q40 << (RED_STEPS - 1);
    end
    if (cmd.red_step) begin
      rx   <= rx_next;
      rdiv <= rdiv >> 1;
    end
    if (cmd.red_step && cmd.red_last) begin
      ma  <= rx_next;
      mb  <= rx_next;
      acc <= '0;
    end
    if (cmd.mul_step) begin
      acc <= acc_next;
      mb  <= mb << DIG_W;
    end
    if (cmd.sq_done) begin
      x2   <= rnd[FRAC_W+TM_W-1:FRAC_W];
      tm   <= TM_W'(1) << FRAC_W;
      sum  <= '0;
      n    <= '0;
      tneg <= 1'b0;
    end
    if (cmd.add_term) begin
      sum  <= tneg ? (sum - tm_s) : (sum + tm_s);
      n    <= n_inc;
      tneg <= ~tneg;
      d    <= dprod[D_W-1:0];
      ma   <= tm;
      mb   <= x2;
      acc  <= '0;
    end
    if (cmd.div_load) begin
      dvd <= rnd[PROD_W-1:FRAC_W];
      rem <= '0;
    end
    if (cmd.div_step) begin
      dvd <= div_q;
      rem <= div_r;
    end
    if (cmd.div_step && cmd.div_last) begin
      tm <= div_q[TM_W-1:0];
    end
    if (cmd.fin) begin
      fneg <= sum_u[SUM_W-1];
      fmag <= radd[SUM_W-1:RND_SHIFT];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cosine         <= cos_sat;
      terms_added    <= OUT_CNT_W'(n);
      hit_term_limit <= tm_gt_thr;
    end
  end

endmodule

// File: dv/cosine_checker.sv
`timescale 1ns / 1ps
// Scoreboard for taylor_cosine_to_accuracy: watches the config port and both
// handshake channels, predicts each cosine result and compares it field by field.
// Stand-alone; instantiated beside the block by testbench.
module cosine_checker #(
  parameter int MAX_TERMS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] angle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] cosine,
  input  logic [4:0]  terms_added,
  input  logic        hit_term_limit,
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] TWO_PI_FIX = (PI_Q62 + 64'd1048576) >> 21;
  localparam logic [31:0] ACC_DEFAULT = 32'd1074;

  typedef struct packed {
    logic [31:0] cosine;
    logic [4:0]  terms;
    logic        hit;
  } cos_result_t;

  cos_result_t pending_cosines[$];
  logic [30:0] accuracy_copy = ACC_DEFAULT[30:0];
  int          errs = 0;

  // (a*b) >> 40 with round to nearest, low 64 bits kept
  function automatic logic [63:0] mul_fix40(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 39);
    return p[103:40];
  endfunction

  // cosine series in sign-magnitude Q24.40, output rounded to Q2.30
  function automatic cos_result_t series_cosine(input logic [31:0] ang,
                                                input logic [30:0] acc);
    logic [63:0] mag, xr, x2, thr, tm, spos, sneg, d, p, us;
    logic signed [63:0] q;
    logic        tneg;
    int          n;
    int          k;
    cos_result_t r;
    mag  = ang[31] ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
    xr   = (mag << 16) % TWO_PI_FIX;
    x2   = mul_fix40(xr, xr);
    thr  = {33'd0, acc} << 10;
    tm   = 64'd1 << 40;
    tneg = 1'b0;
    spos = '0;
    sneg = '0;
    n    = 0;
    k    = 1;
    while (n < MAX_TERMS && tm > thr) begin
      if (tneg) sneg += tm;
      else spos += tm;
      n++;
      d    = 64'((2 * k - 1) * (2 * k));
      p    = mul_fix40(tm, x2);
      tm   = (p + d / 2) / d;
      tneg = !tneg;
      k++;
    end
    us = spos - sneg;
    // halves round away from zero
    if (!us[63]) q = $signed((us + 64'd512) >> 10);
    else q = -$signed((-us + 64'd512) >> 10);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    r.cosine = q[31:0];
    r.terms  = n[4:0];
    r.hit    = (n >= MAX_TERMS) && (tm > thr);
    return r;
  endfunction

  // track config, queue predictions, compare results
  always @(posedge clk) begin
    cos_result_t want;
    if (rst) begin
      accuracy_copy = ACC_DEFAULT[30:0];
      pending_cosines.delete();
    end else begin
      if (in_valid && in_ready)
        pending_cosines.push_back(series_cosine(angle, accuracy_copy));
      if (cfg_write)
        accuracy_copy = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_cosines.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat, cosine %h terms %0d limit %b",
                   $time, cosine, terms_added, hit_term_limit);
        end else begin
          want = pending_cosines.pop_front();
          if (cosine !== want.cosine) begin
            errs++;
            $display("%0t: cosine expected %h actual %h", $time, want.cosine, cosine);
          end
          if (terms_added !== want.terms) begin
            errs++;
            $display("%0t: terms_added expected %0d actual %0d", $time, want.terms,
                     terms_added);
          end
          if (hit_term_limit !== want.hit) begin
            errs++;
            $display("%0t: hit_term_limit expected %b actual %b", $time, want.hit,
                     hit_term_limit);
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= pending_cosines.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the cosine testbench: clock, reset, angle and accuracy stimulus, the
// result consumer and the final verdict. Depends on tca_pkg, the block and
// cosine_checker.
module testbench;

  localparam int MAX_TERMS = 24;
  localparam logic [31:0] PI_Q24   = 32'h0324_3F6A;
  localparam logic [31:0] TWO_PI_Q24 = 32'h0648_7ED5;
  localparam logic [30:0] ACC_ONE  = 31'h4000_0000;
  localparam logic [30:0] ACC_TOP  = 31'h7FFF_FFFF;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [tca_pkg::ACC_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [tca_pkg::ANG_W-1:0]  angle = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [tca_pkg::COS_W-1:0]  cosine;
  logic [tca_pkg::OUT_CNT_W-1:0]     terms_added;
  logic                              hit_term_limit;

  int fail_count;
  int pending;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;

  taylor_cosine_to_accuracy #(
    .MAX_TERMS(MAX_TERMS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .angle(angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cosine(cosine),
    .terms_added(terms_added),
    .hit_term_limit(hit_term_limit)
  );

  cosine_checker #(
    .MAX_TERMS(MAX_TERMS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .angle(angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cosine(cosine),
    .terms_added(terms_added),
    .hit_term_limit(hit_term_limit),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // offer one angle beat after a random gap, return at the accepting edge
  task automatic send_angle(input logic [31:0] a);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle    <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_accuracy(input logic [30:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mix of full-range, within +-4*pi, near multiples of pi and extremes
  function automatic logic [31:0] pick_angle();
    logic [31:0] m;
    int          k;
    case ($urandom_range(0, 3))
      0: pick_angle = $urandom;
      1: begin
        m = $urandom_range(0, 2 * TWO_PI_Q24);
        pick_angle = $urandom_range(0, 1) ? -m : m;
      end
      2: begin
        k = int'($urandom_range(0, 80)) - 40;
        pick_angle = k * int'(PI_Q24) + int'($urandom_range(0, 32)) - 16;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: pick_angle = 32'h7FFF_FFFF;
          1: pick_angle = 32'h8000_0000;
          2: pick_angle = $urandom_range(0, 255);
          default: pick_angle = -$urandom_range(0, 255);
        endcase
      end
    endcase
  endfunction

  // result consumer with random stalls and one long hold-off
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (hold_long) begin
        hold_long = 1'b0;
        stall = 1200;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] reset_angles[];
    logic [30:0] acc;
    reset_angles = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, PI_Q24, -PI_Q24, 32'h0192_1FB5,
                     TWO_PI_Q24, -TWO_PI_Q24, TWO_PI_Q24 + 32'd1,
                     32'h4000_0000, 32'hC000_0000, 32'h0080_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset threshold, then zero threshold, then one and above
    foreach (reset_angles[i]) send_angle(reset_angles[i]);
    drain_results();
    write_accuracy('0);
    send_angle(32'h0);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(TWO_PI_Q24);
    drain_results();
    write_accuracy(ACC_ONE);
    send_angle(32'h0);
    send_angle(PI_Q24);
    drain_results();
    write_accuracy(ACC_TOP);
    send_angle(32'h1234_5678);
    drain_results();

    // random phases, each under its own threshold
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: acc = 31'd1074;
        1: acc = '0;
        2: acc = 31'($urandom_range(0, 2000));
        3: acc = 31'($urandom);
        4: acc = ACC_ONE - 31'd1;
        5: acc = 31'd1;
        6: acc = 31'($urandom_range(0, 1 << 20));
        7: acc = ACC_TOP;
        default: acc = 31'($urandom_range(0, 1 << 14));
      endcase
      write_accuracy(acc);
      if (ph == 2) hold_long = 1'b1;
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 49) == 0) quiet = !quiet;
        send_angle(pick_angle());
      end
      drain_results();
    end

    quiet = 1'b0;
    repeat (320) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tca_pkg.sv
rtl/core/tca_ctrl.sv
rtl/core/tca_dp.sv
rtl/core/taylor_cosine_to_accuracy.sv
dv/cosine_checker.sv
dv/testbench.sv
